@@ rtl/mdp_pkg.sv @@
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared types and constants for the mode parameter data parser.
// ----------------------------------------------------------------------------
package mdp_pkg;

  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] POS_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    REC_HEADER = 2'd0,
    REC_DESC   = 2'd1,
    REC_PAGE   = 2'd2,
    REC_STOP   = 2'd3
  } rec_kind_t;

  // configuration register indexes
  localparam logic CFG_TEN_BYTE    = 1'b0;
  localparam logic CFG_DEVICE_TYPE = 1'b1;

  // peripheral device types with device-specific header bits
  localparam logic [4:0] DEV_DISK    = 5'd0;
  localparam logic [4:0] DEV_TAPE    = 5'd1;
  localparam logic [4:0] DEV_PRINTER = 5'd2;
  localparam logic [4:0] DEV_MMC     = 5'd5;
  localparam logic [4:0] DEV_OPTICAL = 5'd7;

  typedef struct packed {
    rec_kind_t    kind;
    logic [7:0]   medium_type;
    logic         write_protected;
    logic         dpo_fua;
    logic         ebc;
    logic [3:0]   speed;
    logic [2:0]   buffered_mode;
    logic [7:0]   density;
    logic [63:0]  block_count;
    logic [31:0]  block_length;
    logic [13:0]  page_id;
    logic [16:0]  page_size;
  } mdp_rec_t;

endpackage

@@ rtl/mdp_in_stage.sv @@
// ----------------------------------------------------------------------------
// mdp_in_stage
// Input register: holds one response byte until the parser takes it.
// ----------------------------------------------------------------------------
module mdp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       take,
  output logic       full,
  output logic [7:0] item_byte,
  output logic       item_first
);

  logic accept;

  assign in_stall = full && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte  <= data_byte;
      item_first <= first_byte;
    end
  end

endmodule

@@ rtl/mdp_parser.sv @@
// ----------------------------------------------------------------------------
// mdp_parser
// Parse state and per-byte logic: header, block descriptors, page headers.
// ----------------------------------------------------------------------------
module mdp_parser import mdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        take,
  input  logic [7:0]  item_byte,
  input  logic        item_first,
  output logic        rec_valid,
  output mdp_rec_t    rec
);

  logic        ten_byte;
  logic [4:0]  device_type;

  logic [16:0] byte_pos,   byte_pos_next;
  logic [16:0] list_len,   list_len_next;
  logic [7:0]  med_type,   med_type_next;
  logic [7:0]  dev_spec,   dev_spec_next;
  logic        long_lba,   long_lba_next;
  logic [7:0]  bdl_hi,     bdl_hi_next;
  logic [12:0] desc_cnt,   desc_cnt_next;
  logic [63:0] blocks,     blocks_next;
  logic [31:0] blk_len,    blk_len_next;
  logic [16:0] page_start, page_start_next;
  logic [23:0] page_hdr,   page_hdr_next;
  logic        stopped,    stopped_next;

  logic [16:0] p;
  logic [7:0]  b;
  logic        lng;
  logic [3:0]  rel_d;
  logic [16:0] rel_p;
  logic [15:0] bdl;
  logic [12:0] cnt;
  logic [16:0] dend;
  logic [16:0] desc_lim;
  logic [16:0] size;
  logic [17:0] sum;
  logic [17:0] hdr_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ten_byte    <= 1'b1;
      device_type <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEN_BYTE:    ten_byte    <= cfg_data[0];
        CFG_DEVICE_TYPE: device_type <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_pos_next   = byte_pos;
    list_len_next   = list_len;
    med_type_next   = med_type;
    dev_spec_next   = dev_spec;
    long_lba_next   = long_lba;
    bdl_hi_next     = bdl_hi;
    desc_cnt_next   = desc_cnt;
    blocks_next     = blocks;
    blk_len_next    = blk_len;
    page_start_next = page_start;
    page_hdr_next   = page_hdr;
    stopped_next    = stopped;
    rec       = '0;
    rec_valid = 1'b0;
    p        = '0;
    b        = item_byte;
    lng      = 1'b0;
    rel_d    = '0;
    rel_p    = '0;
    bdl      = '0;
    cnt      = '0;
    dend     = '0;
    desc_lim = '0;
    size     = '0;
    sum      = '0;
    hdr_end  = '0;

    if (take) begin
      if (item_first) begin
        byte_pos_next   = '0;
        list_len_next   = '0;
        med_type_next   = '0;
        dev_spec_next   = '0;
        long_lba_next   = 1'b0;
        bdl_hi_next     = '0;
        desc_cnt_next   = '0;
        blocks_next     = '0;
        blk_len_next    = '0;
        page_start_next = '0;
        page_hdr_next   = '0;
        stopped_next    = 1'b0;
      end

      if (!stopped_next && byte_pos_next != POS_MAX) begin
        p = byte_pos_next;
        byte_pos_next = p + 17'd1;
        lng = ten_byte && long_lba_next;
        // descriptor area end for the current layout
        desc_lim = (ten_byte ? 17'd8 : 17'd4) +
                   (lng ? {desc_cnt_next, 4'b0000} : {1'b0, desc_cnt_next, 3'b000});

        if (ten_byte && p[16:3] == '0) begin
          // ten-byte mode header
          unique case (p[2:0])
            3'd0: list_len_next = {1'b0, b, 8'h00};
            3'd1: list_len_next = {1'b0, list_len_next[15:8], 8'h00} + {9'b0, b} + 17'd2;
            3'd2: med_type_next = b;
            3'd3: dev_spec_next = b;
            3'd4: long_lba_next = b[0];
            3'd5: ;
            3'd6: bdl_hi_next   = b;
            3'd7: begin
              bdl = {bdl_hi_next, b};
              if (long_lba_next) begin
                cnt  = {1'b0, bdl[15:4]};
                dend = 17'd8 + {cnt, 4'b0000};
              end else begin
                cnt  = bdl[15:3];
                dend = 17'd8 + {1'b0, cnt, 3'b000};
              end
              rec_valid = 1'b1;
            end
            default: ;
          endcase
        end else if (!ten_byte && p[16:2] == '0) begin
          // six-byte mode header
          unique case (p[1:0])
            2'd0: list_len_next = {9'b0, b} + 17'd1;
            2'd1: med_type_next = b;
            2'd2: dev_spec_next = b;
            2'd3: begin
              cnt  = {8'b0, b[7:3]};
              dend = 17'd4 + {1'b0, cnt, 3'b000};
              rec_valid = 1'b1;
            end
            default: ;
          endcase
        end else if (p < desc_lim) begin
          // offset within the descriptor; header length is 4 or 8
          if (lng) begin
            rel_d = {~p[3], p[2:0]};
          end else if (ten_byte) begin
            rel_d = {1'b0, p[2:0]};
          end else begin
            rel_d = {1'b0, ~p[2], p[1:0]};
          end
          if (rel_d == 4'd0) begin
            blocks_next  = '0;
            blk_len_next = '0;
          end
          if (lng) begin
            if (rel_d < 4'd8) begin
              blocks_next = {blocks_next[55:0], b};
            end else if (rel_d >= 4'd12) begin
              blk_len_next = {blk_len_next[23:0], b};
            end
          end else begin
            if (rel_d < 4'd4) begin
              blocks_next = {32'b0, blocks_next[23:0], b};
            end else if (rel_d >= 4'd5) begin
              blk_len_next = {8'b0, blk_len_next[15:0], b};
            end
          end
          if (rel_d == (lng ? 4'd15 : 4'd7)) begin
            rec_valid = 1'b1;
            rec.kind  = REC_DESC;
            if (lng) begin
              rec.block_count = blocks_next;
            end else if (ten_byte && device_type == DEV_DISK) begin
              rec.block_count = {32'b0, blocks_next[31:0]};
            end else begin
              rec.density     = blocks_next[31:24];
              rec.block_count = {40'b0, blocks_next[23:0]};
            end
            rec.block_length = blk_len_next;
          end
        end else if (p < list_len_next && p >= page_start_next) begin
          rel_p = p - page_start_next;
          if (rel_p == 17'd0) begin
            page_hdr_next = {b, 16'h0000};
            hdr_end = {1'b0, p} + (b[6] ? 18'd3 : 18'd1);
            if (b[5:0] == 6'd0) begin
              // page 0 runs to the end of the list
              rec_valid       = 1'b1;
              rec.kind        = REC_PAGE;
              rec.page_size   = list_len_next - p;
              page_start_next = list_len_next;
            end else if (hdr_end >= {1'b0, list_len_next}) begin
              stopped_next = 1'b1;
              rec_valid    = 1'b1;
              rec.kind     = REC_STOP;
            end
          end else if (rel_p == 17'd1) begin
            page_hdr_next[15:8] = b;
            page_hdr_next[7:0]  = 8'h00;
            if (!page_hdr_next[22]) begin
              size = {9'b0, b} + 17'd2;
              sum  = {1'b0, page_start_next} + {1'b0, size};
              page_start_next = sum[17] ? POS_MAX : sum[16:0];
              rec_valid     = 1'b1;
              rec.kind      = REC_PAGE;
              rec.page_id   = {page_hdr_next[21:16], 8'h00};
              rec.page_size = size;
            end
          end else if (rel_p == 17'd2) begin
            page_hdr_next[7:0] = b;
          end else if (rel_p == 17'd3 && page_hdr_next[22]) begin
            size = {1'b0, page_hdr_next[7:0], b} + 17'd4;
            sum  = {1'b0, page_start_next} + {1'b0, size};
            page_start_next = sum[17] ? POS_MAX : sum[16:0];
            rec_valid     = 1'b1;
            rec.kind      = REC_PAGE;
            rec.page_id   = {page_hdr_next[21:16], page_hdr_next[15:8]};
            rec.page_size = size;
          end
        end

        // header record, with the device-specific bits picked by device type
        if (rec_valid && (p[16:3] == '0) && (ten_byte ? p[2:0] == 3'd7 : p[2:0] == 3'd3)) begin
          desc_cnt_next   = cnt;
          page_start_next = dend;
          rec.kind        = REC_HEADER;
          rec.medium_type = med_type_next;
          unique case (device_type)
            DEV_DISK, DEV_MMC: begin
              rec.write_protected = dev_spec_next[7];
              rec.dpo_fua         = dev_spec_next[4];
            end
            DEV_TAPE: begin
              rec.write_protected = dev_spec_next[7];
              rec.speed           = dev_spec_next[3:0];
              rec.buffered_mode   = dev_spec_next[6:4];
            end
            DEV_PRINTER: rec.buffered_mode = dev_spec_next[6:4];
            DEV_OPTICAL: begin
              rec.write_protected = dev_spec_next[7];
              rec.dpo_fua         = dev_spec_next[4];
              rec.ebc             = dev_spec_next[0];
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      list_len   <= '0;
      med_type   <= '0;
      dev_spec   <= '0;
      long_lba   <= 1'b0;
      bdl_hi     <= '0;
      desc_cnt   <= '0;
      blocks     <= '0;
      blk_len    <= '0;
      page_start <= '0;
      page_hdr   <= '0;
      stopped    <= 1'b1;
    end else begin
      byte_pos   <= byte_pos_next;
      list_len   <= list_len_next;
      med_type   <= med_type_next;
      dev_spec   <= dev_spec_next;
      long_lba   <= long_lba_next;
      bdl_hi     <= bdl_hi_next;
      desc_cnt   <= desc_cnt_next;
      blocks     <= blocks_next;
      blk_len    <= blk_len_next;
      page_start <= page_start_next;
      page_hdr   <= page_hdr_next;
      stopped    <= stopped_next;
    end
  end

  // idle parser stays silent until a new response starts
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (stopped && !item_first) |-> !rec_valid)
    else $error("record produced while parser idle");

  // stop record always leaves the parser idle
  a_stop_idles: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec.kind == REC_STOP) |=> stopped)
    else $error("stop record did not idle the parser");

  // records only come from a byte that is being taken
  a_rec_needs_take: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> take)
    else $error("record produced without a byte");

endmodule

@@ rtl/mdp_out_stage.sv @@
// ----------------------------------------------------------------------------
// mdp_out_stage
// Result register: holds one record until the downstream side takes it.
// ----------------------------------------------------------------------------
module mdp_out_stage import mdp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_full,
  input  logic     rec_valid,
  input  mdp_rec_t rec,
  output logic     take,
  output logic     out_valid,
  input  logic     out_stall,
  output mdp_rec_t out_rec
);

  logic open;

  // register can load when empty or when its record leaves this cycle
  assign open = !out_valid || !out_stall;
  assign take = in_full && open;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (open) begin
      out_valid <= take && rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && rec_valid) begin
      out_rec <= rec;
    end
  end

endmodule

@@ rtl/scsi_mode_data_parser_top.sv @@
// ----------------------------------------------------------------------------
// scsi_mode_data_parser_top
// Byte-stream parser for MODE SENSE(6)/(10) parameter lists.
// ----------------------------------------------------------------------------
// Takes one response byte per clock and, while out_stall is low, sustains one
// byte per cycle with no bubbles. Each byte passes an input register and the
// parse logic, and a record it completes is presented from a result register.
// A header record follows the last header byte, one descriptor record follows
// the last byte of each block descriptor, and one page record follows each
// page header; a page header cut off by the list length gives a stop record
// and the parser then ignores bytes until first_byte marks a new response. The
// user must write registers only while idle; the block does not enforce it.
module scsi_mode_data_parser_top import mdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [7:0]  medium_type,
  output logic        write_protected,
  output logic        dpo_fua,
  output logic        ebc,
  output logic [3:0]  speed,
  output logic [2:0]  buffered_mode,
  output logic [7:0]  density,
  output logic [63:0] block_count,
  output logic [31:0] block_length,
  output logic [13:0] page_id,
  output logic [16:0] page_size
);

  logic     take;
  logic     full;
  logic [7:0] item_byte;
  logic     item_first;
  logic     rec_valid;
  mdp_rec_t rec;
  mdp_rec_t out_rec;

  mdp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .take       (take),
    .full       (full),
    .item_byte  (item_byte),
    .item_first (item_first)
  );

  mdp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .item_byte  (item_byte),
    .item_first (item_first),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  mdp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_full   (full),
    .rec_valid (rec_valid),
    .rec       (rec),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  assign record_kind     = out_rec.kind;
  assign medium_type     = out_rec.medium_type;
  assign write_protected = out_rec.write_protected;
  assign dpo_fua         = out_rec.dpo_fua;
  assign ebc             = out_rec.ebc;
  assign speed           = out_rec.speed;
  assign buffered_mode   = out_rec.buffered_mode;
  assign density         = out_rec.density;
  assign block_count     = out_rec.block_count;
  assign block_length    = out_rec.block_length;
  assign page_id         = out_rec.page_id;
  assign page_size       = out_rec.page_size;

endmodule
